// ----- src/x25519_pkg.sv -----
// ----------------------------------------------------------------------------
// x25519_pkg
// Shared types, field constants and the ladder micro-program.
// ----------------------------------------------------------------------------
package x25519_pkg;

  localparam int WORDS_PER_OPERAND = 4;

  // p = 2^255 - 19
  localparam logic [255:0] P_MOD  = {1'b0, {250{1'b1}}, 5'b01101};
  // 4p, added ahead of a subtraction so the difference stays positive
  localparam logic [257:0] FOUR_P = {P_MOD, 2'b00};
  localparam logic [255:0] A24    = 256'd121666;

  localparam logic [4:0] LADDER_LAST = 5'd17;  // 18 ops per ladder step
  localparam logic [7:0] LADDER_TOP  = 8'd254;
  localparam logic [7:0] EXP_TOP     = 8'd254;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } fop_t;

  typedef enum logic [3:0] {
    S_X1, S_X2, S_Z2, S_X3, S_Z3,
    S_A, S_AA, S_B, S_BB, S_E,
    S_C, S_D, S_DA, S_CB, S_T, S_K
  } slot_t;

  typedef enum logic [1:0] {
    LD_U,
    LD_ONE,
    LD_ZERO,
    LD_A24
  } ld_t;

  typedef struct packed {
    fop_t  op;
    slot_t dst;
    slot_t sa;
    slot_t sb;
  } uop_t;

  typedef struct packed {
    logic       buf_we;
    logic [1:0] buf_idx;
    logic       ld_we;
    ld_t        ld_sel;
    logic       wb_we;
    slot_t      wr_slot;
    logic       rd_en;
    slot_t      rd_a;
    slot_t      rd_b;
    logic       fau_start;
    fop_t       fau_op;
    logic       can_load;
    logic       can_step;
    logic [1:0] out_idx;
    logic [7:0] pos;
  } dp_cmd_t;

  typedef struct packed {
    logic fau_done;
    logic scal_bit;
  } dp_sts_t;

  // One ladder step in unswapped slot names.
  function automatic uop_t ladder_uop(input logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:    u = '{OP_ADD, S_A,  S_X2, S_Z2};
      5'd1:    u = '{OP_MUL, S_AA, S_A,  S_A};
      5'd2:    u = '{OP_SUB, S_B,  S_X2, S_Z2};
      5'd3:    u = '{OP_MUL, S_BB, S_B,  S_B};
      5'd4:    u = '{OP_SUB, S_E,  S_AA, S_BB};
      5'd5:    u = '{OP_ADD, S_C,  S_X3, S_Z3};
      5'd6:    u = '{OP_SUB, S_D,  S_X3, S_Z3};
      5'd7:    u = '{OP_MUL, S_DA, S_D,  S_A};
      5'd8:    u = '{OP_MUL, S_CB, S_C,  S_B};
      5'd9:    u = '{OP_ADD, S_T,  S_DA, S_CB};
      5'd10:   u = '{OP_MUL, S_X3, S_T,  S_T};
      5'd11:   u = '{OP_SUB, S_T,  S_DA, S_CB};
      5'd12:   u = '{OP_MUL, S_T,  S_T,  S_T};
      5'd13:   u = '{OP_MUL, S_Z3, S_X1, S_T};
      5'd14:   u = '{OP_MUL, S_X2, S_AA, S_BB};
      5'd15:   u = '{OP_MUL, S_T,  S_E,  S_K};
      5'd16:   u = '{OP_ADD, S_T,  S_BB, S_T};
      default: u = '{OP_MUL, S_Z2, S_E,  S_T};
    endcase
    return u;
  endfunction

  // Bits of p-2, all ones above bit 4, then 01011.
  function automatic logic inv_bit(input logic [7:0] e);
    return (e >= 8'd5) || (e == 8'd3) || (e == 8'd1) || (e == 8'd0);
  endfunction

endpackage

// ----- src/x25519_if.sv -----
// ----------------------------------------------------------------------------
// x25519 channel interfaces
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface x25519_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] scalar_word;
  logic [63:0] point_word;
  logic        use_base_point;
  logic        last_word;

  modport source (output valid, scalar_word, point_word, use_base_point, last_word,
                  input ready);
  modport sink   (input valid, scalar_word, point_word, use_base_point, last_word,
                  output ready);
endinterface

interface x25519_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;
  logic        result_last;
  logic        all_zero;

  modport source (output valid, result_word, result_last, all_zero, input ready);
  modport sink   (input valid, result_word, result_last, all_zero, output ready);
endinterface

// ----- src/x25519_fau.sv -----
// ----------------------------------------------------------------------------
// x25519_fau
// Field unit mod 2^255-19: serial 32x32 MAC multiply, add, subtract.
// ----------------------------------------------------------------------------
module x25519_fau (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  x25519_pkg::fop_t    op,
  input  logic [255:0]        a,
  input  logic [255:0]        b,
  output logic                done,
  output logic [255:0]        res
);

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_RED, F_NEG, F_ADD, F_FA, F_FB} fstate_t;

  localparam logic [6:0] MAC_COUNT = 7'd64;
  localparam logic [3:0] LAST_COL  = 4'd14;

  fstate_t          st_r;
  x25519_pkg::fop_t op_r;
  logic [6:0]   m_r;
  logic [3:0]   col_r;
  logic [2:0]   i_r;
  logic [63:0]  prod_r;
  logic         pv_r;
  logic         last_r;
  logic [3:0]   colt_r;
  logic [71:0]  acc_r;
  logic [255:0] lw_r;
  logic [255:0] hw_r;
  logic [2:0]   rc_r;
  logic [255:0] lo_r;
  logic [6:0]   hi_r;
  logic [257:0] nb_r;
  logic         done_r;

  logic [2:0]   i_hi;
  logic [3:0]   j;
  logic [3:0]   col_inc;
  logic [2:0]   i_first;
  logic [31:0]  a_w;
  logic [31:0]  b_w;
  logic [71:0]  sum;
  logic [38:0]  acc2;
  logic [12:0]  hi38;
  logic [256:0] fold;
  logic [257:0] addv;
  logic [257:0] negb;

  // column-order walk over the 8x8 digit products
  assign i_hi    = (col_r > 4'd7) ? 3'd7 : col_r[2:0];
  assign j       = col_r - {1'b0, i_r};
  assign col_inc = col_r + 4'd1;
  assign i_first = (col_inc > 4'd7) ? 3'(col_inc - 4'd7) : 3'd0;
  assign a_w     = a[{i_r, 5'b0} +: 32];
  assign b_w     = b[{j[2:0], 5'b0} +: 32];
  assign sum     = acc_r + {8'd0, prod_r};

  // 2^256 = 38 mod p
  assign acc2 = {32'd0, hi_r} + {7'd0, lw_r[31:0]} + ({7'd0, hw_r[31:0]} * 39'd38);
  assign hi38 = {6'd0, hi_r} * 13'd38;
  assign fold = {1'b0, lo_r} + {244'd0, hi38};
  assign addv = {2'b00, a} + nb_r;
  assign negb = (op_r == x25519_pkg::OP_SUB) ? (x25519_pkg::FOUR_P - {2'b00, b})
                                             : {2'b00, b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (pv_r) begin
        if (last_r) begin
          if (!colt_r[3]) lw_r[{colt_r[2:0], 5'b0} +: 32] <= sum[31:0];
          else            hw_r[{colt_r[2:0], 5'b0} +: 32] <= sum[31:0];
          if (colt_r == LAST_COL) hw_r[255:224] <= sum[63:32];
          acc_r <= {32'd0, sum[71:32]};
        end else begin
          acc_r <= sum;
        end
      end
      unique case (st_r)
        F_IDLE: begin
          if (start) begin
            op_r <= op;
            if (op == x25519_pkg::OP_MUL) begin
              st_r  <= F_MAC;
              m_r   <= 7'd0;
              col_r <= 4'd0;
              i_r   <= 3'd0;
              acc_r <= 72'd0;
            end else begin
              st_r <= F_NEG;
            end
          end
        end
        F_MAC: begin
          if (m_r != MAC_COUNT) begin
            prod_r <= a_w * b_w;
            pv_r   <= 1'b1;
            last_r <= (i_r == i_hi);
            colt_r <= col_r;
            m_r    <= m_r + 7'd1;
            if (i_r == i_hi) begin
              col_r <= col_inc;
              i_r   <= i_first;
            end else begin
              i_r <= i_r + 3'd1;
            end
          end else begin
            pv_r <= 1'b0;
            st_r <= F_RED;
            rc_r <= 3'd0;
            hi_r <= 7'd0;
          end
        end
        F_RED: begin
          lo_r <= {acc2[31:0], lo_r[255:32]};
          hi_r <= acc2[38:32];
          lw_r <= {32'd0, lw_r[255:32]};
          hw_r <= {32'd0, hw_r[255:32]};
          rc_r <= rc_r + 3'd1;
          if (rc_r == 3'd7) st_r <= F_FA;
        end
        F_NEG: begin
          nb_r <= negb;
          st_r <= F_ADD;
        end
        F_ADD: begin
          lo_r <= addv[255:0];
          hi_r <= {5'd0, addv[257:256]};
          st_r <= F_FA;
        end
        F_FA: begin
          lo_r <= fold[255:0];
          hi_r <= {6'd0, fold[256]};
          st_r <= F_FB;
        end
        F_FB: begin
          lo_r   <= fold[255:0];
          hi_r   <= 7'd0;
          done_r <= 1'b1;
          st_r   <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = lo_r;

endmodule

// ----- src/x25519_dp.sv -----
// ----------------------------------------------------------------------------
// x25519_dp
// Operand buffers, field register file, field unit and final reduction.
// ----------------------------------------------------------------------------
module x25519_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [63:0]           scalar_word,
  input  logic [63:0]           point_word,
  input  logic                  use_base_point,
  input  logic                  last_word,
  input  x25519_pkg::dp_cmd_t   cmd,
  output x25519_pkg::dp_sts_t   sts,
  output logic [63:0]           result_word,
  output logic                  result_last,
  output logic                  all_zero
);

  logic [63:0]  sbuf_r [x25519_pkg::WORDS_PER_OPERAND];
  logic [63:0]  pbuf_r [x25519_pkg::WORDS_PER_OPERAND];
  logic         ub_r;
  logic [255:0] rf_r [16];
  logic [255:0] rda_r;
  logic [255:0] rdb_r;
  logic [255:0] canon_r;

  logic [255:0] kflat;
  logic [255:0] kcl;
  logic [255:0] pflat;
  logic [255:0] uval;
  logic [255:0] ld_data;
  logic [255:0] wr_data;
  logic [255:0] fau_res;
  logic         fau_done;
  logic [256:0] diff;

  assign kflat = {sbuf_r[3], sbuf_r[2], sbuf_r[1], sbuf_r[0]};
  assign pflat = {pbuf_r[3], pbuf_r[2], pbuf_r[1], pbuf_r[0]};
  // clamp: clear low 3 bits and bit 255, set bit 254
  assign kcl   = {2'b01, kflat[253:3], 3'b000};
  assign uval  = ub_r ? 256'd9 : {1'b0, pflat[254:0]};

  always_comb begin
    unique case (cmd.ld_sel)
      x25519_pkg::LD_U:    ld_data = uval;
      x25519_pkg::LD_ONE:  ld_data = 256'd1;
      x25519_pkg::LD_ZERO: ld_data = 256'd0;
      default:             ld_data = x25519_pkg::A24;
    endcase
  end

  assign wr_data = cmd.ld_we ? ld_data : fau_res;
  assign diff    = {1'b0, canon_r} - {1'b0, x25519_pkg::P_MOD};

  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      sbuf_r[cmd.buf_idx] <= scalar_word;
      pbuf_r[cmd.buf_idx] <= point_word;
      if (last_word) ub_r <= use_base_point;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_we || cmd.wb_we) rf_r[cmd.wr_slot] <= wr_data;
    if (cmd.rd_en) begin
      rda_r <= rf_r[cmd.rd_a];
      rdb_r <= rf_r[cmd.rd_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.can_load)                 canon_r <= rda_r;
    else if (cmd.can_step && !diff[256]) canon_r <= diff[255:0];
  end

  x25519_fau u_fau (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.fau_start),
    .op    (cmd.fau_op),
    .a     (rda_r),
    .b     (rdb_r),
    .done  (fau_done),
    .res   (fau_res)
  );

  assign sts.fau_done = fau_done;
  assign sts.scal_bit = kcl[cmd.pos];

  assign result_word = canon_r[{cmd.out_idx, 6'b0} +: 64];
  assign result_last = (cmd.out_idx == 2'd3);
  assign all_zero    = result_last && (canon_r == 256'd0);

endmodule

// ----- src/x25519_ctrl.sv -----
// ----------------------------------------------------------------------------
// x25519_ctrl
// Sequencer: word intake, ladder, inversion, reduction and result beats.
// ----------------------------------------------------------------------------
module x25519_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output x25519_pkg::dp_cmd_t  cmd,
  input  x25519_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_NEXT, ST_RD, ST_EX, ST_WT, ST_ADV,
    ST_LDR, ST_CRD, ST_CLD, ST_CS1, ST_CS2, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_LAD, PH_SQ, PH_MULZ, PH_FIN} phase_t;

  state_t           st_r;
  phase_t           ph_r;
  logic [1:0]       wc_r;
  logic [2:0]       ic_r;
  logic [4:0]       idx_r;
  logic [7:0]       pos_r;
  logic [7:0]       e_r;
  logic [1:0]       oi_r;
  x25519_pkg::uop_t cur_r;
  x25519_pkg::uop_t uop;

  // conditional swap done by renaming the ladder's working slots
  function automatic x25519_pkg::slot_t remap(input x25519_pkg::slot_t s, input logic sw);
    x25519_pkg::slot_t r;
    r = s;
    if (sw) begin
      unique case (s)
        x25519_pkg::S_X2: r = x25519_pkg::S_X3;
        x25519_pkg::S_X3: r = x25519_pkg::S_X2;
        x25519_pkg::S_Z2: r = x25519_pkg::S_Z3;
        x25519_pkg::S_Z3: r = x25519_pkg::S_Z2;
        default:          r = s;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    x25519_pkg::uop_t lu;
    lu = x25519_pkg::ladder_uop(idx_r);
    unique case (ph_r)
      PH_LAD: uop = '{lu.op, remap(lu.dst, sts.scal_bit), remap(lu.sa, sts.scal_bit),
                      remap(lu.sb, sts.scal_bit)};
      PH_SQ:  uop = '{x25519_pkg::OP_MUL, x25519_pkg::S_A, x25519_pkg::S_A,
                      x25519_pkg::S_A};
      PH_MULZ: uop = '{x25519_pkg::OP_MUL, x25519_pkg::S_A, x25519_pkg::S_A,
                       x25519_pkg::S_Z2};
      default: uop = '{x25519_pkg::OP_MUL, x25519_pkg::S_T, x25519_pkg::S_X2,
                       x25519_pkg::S_A};
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.buf_idx   = wc_r;
    cmd.pos       = pos_r;
    cmd.out_idx   = oi_r;
    cmd.fau_op    = cur_r.op;
    cmd.wr_slot   = cur_r.dst;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.buf_we = in_valid;
      end
      ST_INIT: begin
        cmd.ld_we = 1'b1;
        unique case (ic_r)
          3'd0: begin cmd.wr_slot = x25519_pkg::S_X1; cmd.ld_sel = x25519_pkg::LD_U;    end
          3'd1: begin cmd.wr_slot = x25519_pkg::S_X2; cmd.ld_sel = x25519_pkg::LD_ONE;  end
          3'd2: begin cmd.wr_slot = x25519_pkg::S_Z2; cmd.ld_sel = x25519_pkg::LD_ZERO; end
          3'd3: begin cmd.wr_slot = x25519_pkg::S_X3; cmd.ld_sel = x25519_pkg::LD_U;    end
          3'd4: begin cmd.wr_slot = x25519_pkg::S_Z3; cmd.ld_sel = x25519_pkg::LD_ONE;  end
          default: begin
            cmd.wr_slot = x25519_pkg::S_K;
            cmd.ld_sel  = x25519_pkg::LD_A24;
          end
        endcase
      end
      ST_LDR: begin
        cmd.ld_we   = 1'b1;
        cmd.wr_slot = x25519_pkg::S_A;
        cmd.ld_sel  = x25519_pkg::LD_ONE;
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_a  = cur_r.sa;
        cmd.rd_b  = cur_r.sb;
      end
      ST_EX:  cmd.fau_start = 1'b1;
      ST_WT:  cmd.wb_we = sts.fau_done;
      ST_CRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_a  = x25519_pkg::S_T;
        cmd.rd_b  = x25519_pkg::S_T;
      end
      ST_CLD: cmd.can_load = 1'b1;
      ST_CS1, ST_CS2: cmd.can_step = 1'b1;
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      wc_r <= 2'd0;
      oi_r <= 2'd0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_last) begin
              wc_r <= 2'd0;
              ic_r <= 3'd0;
              st_r <= ST_INIT;
            end else begin
              wc_r <= wc_r + 2'd1;
            end
          end
        end
        ST_INIT: begin
          ic_r <= ic_r + 3'd1;
          if (ic_r == 3'd5) begin
            ph_r  <= PH_LAD;
            idx_r <= 5'd0;
            pos_r <= x25519_pkg::LADDER_TOP;
            st_r  <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          cur_r <= uop;
          st_r  <= ST_RD;
        end
        ST_RD: st_r <= ST_EX;
        ST_EX: st_r <= ST_WT;
        ST_WT: if (sts.fau_done) st_r <= ST_ADV;
        ST_ADV: begin
          st_r <= ST_NEXT;
          unique case (ph_r)
            PH_LAD: begin
              if (idx_r == x25519_pkg::LADDER_LAST) begin
                idx_r <= 5'd0;
                if (pos_r == 8'd0) st_r  <= ST_LDR;
                else               pos_r <= pos_r - 8'd1;
              end else begin
                idx_r <= idx_r + 5'd1;
              end
            end
            PH_SQ: begin
              if (x25519_pkg::inv_bit(e_r)) ph_r <= PH_MULZ;
              else if (e_r == 8'd0)         ph_r <= PH_FIN;
              else                          e_r  <= e_r - 8'd1;
            end
            PH_MULZ: begin
              if (e_r == 8'd0) begin
                ph_r <= PH_FIN;
              end else begin
                ph_r <= PH_SQ;
                e_r  <= e_r - 8'd1;
              end
            end
            default: st_r <= ST_CRD;
          endcase
        end
        ST_LDR: begin
          ph_r <= PH_SQ;
          e_r  <= x25519_pkg::EXP_TOP;
          st_r <= ST_NEXT;
        end
        ST_CRD: st_r <= ST_CLD;
        ST_CLD: st_r <= ST_CS1;
        ST_CS1: st_r <= ST_CS2;
        ST_CS2: st_r <= ST_OUT;
        ST_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 2'd1;
            if (oi_r == 2'd3) st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/x25519_scalar_multiply.sv -----
// ----------------------------------------------------------------------------
// x25519_scalar_multiply
// X25519 scalar multiplication: clamped Montgomery ladder over GF(2^255-19).
// ----------------------------------------------------------------------------
// Feed the scalar and peer u-coordinate as four 64-bit little-endian beats,
// least significant first; the beat with last_word set starts the job, and
// use_base_point on that beat selects u = 9. Words without last_word return
// nothing and may arrive back to back. A job runs about 3,060 field
// multiplications (10 per ladder step over 255 steps, 508 for the
// inversion, one for X/Z), all on one shared 32x32 multiply-accumulate
// (64 digit products, then an 8-word fold by 38), plus about 2,040 adds
// and subtracts. The input is not ready during a job. The result then
// leaves as four 64-bit beats, least significant first, fully reduced
// mod p; result_last marks the fourth beat and all_zero on it flags a
// zero result (low-order or zero point).
// ----------------------------------------------------------------------------
module x25519_scalar_multiply (
  input  logic           clk,
  input  logic           rst_n,
  x25519_in_if.sink      in_port,
  x25519_out_if.source   out_port
);

  x25519_pkg::dp_cmd_t cmd;
  x25519_pkg::dp_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  // sequencer: intake, ladder/inversion program, result beats
  x25519_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_last   (in_port.last_word),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_port.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // buffers, register file, field unit, canonical reduction
  x25519_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .scalar_word    (in_port.scalar_word),
    .point_word     (in_port.point_word),
    .use_base_point (in_port.use_base_point),
    .last_word      (in_port.last_word),
    .cmd            (cmd),
    .sts            (sts),
    .result_word    (out_port.result_word),
    .result_last    (out_port.result_last),
    .all_zero       (out_port.all_zero)
  );

  assign in_port.ready  = in_ready;
  assign out_port.valid = out_valid;

  // intake and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_port.ready && out_port.valid))
    else $error("input ready while results pending");

  // zero flag only on the last beat
  a_zero_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_port.valid && out_port.all_zero) |-> out_port.result_last)
    else $error("all_zero outside last beat");

  // canonical result keeps bit 255 clear
  a_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_port.valid && out_port.result_last) |-> !out_port.result_word[63])
    else $error("result not reduced");

endmodule
